>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define SHTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker: same-cycle property failed");

// Check the consequent in the cycle after the antecedent.
`define SHTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker: next-cycle property failed");

`endif

>>> sv/shtt_pkg.sv
// Types, codes and constants of the sample history trend tracker.
`timescale 1ns / 1ps
package shtt_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_INTERVAL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SAMPLE_AGE        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TREND_WINDOW          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_THRESHOLD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE_THRESHOLD = 3'd4;

    localparam logic [16:0] RECORD_INTERVAL_RESET       = 17'd3300;
    localparam logic [19:0] MAX_SAMPLE_AGE_RESET        = 20'd86400;
    localparam logic [19:0] TREND_WINDOW_RESET          = 20'd10800;
    localparam logic [14:0] PRESSURE_THRESHOLD_RESET    = 15'd10;
    localparam logic [14:0] TEMPERATURE_THRESHOLD_RESET = 15'd50;

    typedef enum logic [1:0] {
        TR_UNKNOWN = 2'd0,
        TR_UP      = 2'd1,
        TR_FLAT    = 2'd2,
        TR_DOWN    = 2'd3
    } trend_t;

    typedef enum logic [1:0] {
        AGE_KEEP,
        AGE_INTERVAL,
        AGE_WINDOW
    } age_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_DECIDE,
        ST_SHIFT,
        ST_APPEND,
        ST_SCAN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [16:0] record_interval;
        logic [19:0] max_sample_age;
        logic [19:0] trend_window;
        logic [14:0] pressure_threshold;
        logic [14:0] temperature_threshold;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_seconds;
        logic signed [15:0] pressure_tenths;
        logic               pressure_known;
        logic signed [15:0] temperature_hundredths;
        logic               temperature_known;
    } in_t;

    typedef struct packed {
        trend_t      pressure_trend;
        trend_t      indoor_trend;
        logic        sample_recorded;
        logic [4:0]  stored_count;
    } out_t;

    // One stored sample of the ring.
    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [15:0] pressure;
        logic signed [15:0] temperature;
        logic               pressure_ok;
        logic               temperature_ok;
    } entry_t;

endpackage

>>> sv/shtt_ring.sv
// Sample ring storage: one write port, one registered read port.
`timescale 1ns / 1ps
module shtt_ring
    import shtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(SLOTS)-1:0]   waddr,
    input  entry_t                     wdata,
    input  logic [$clog2(SLOTS)-1:0]   raddr,
    output entry_t                     rdata
);

    entry_t mem [SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/shtt_age_unit.sv
// Shared age subtractor and compare unit.
`timescale 1ns / 1ps
module shtt_age_unit
    import shtt_pkg::*;
(
    input  cfg_t        cfg,
    input  age_op_t     op,
    input  logic [31:0] now,
    input  logic [31:0] stamp,
    output logic        hit
);

    logic [31:0] age;

    assign age = now - stamp;

    always_comb
    begin
        unique case (op)
            AGE_KEEP:
            begin
                hit = (stamp <= now) && (age < {12'd0, cfg.max_sample_age});
            end
            AGE_INTERVAL:
            begin
                hit = age >= {15'd0, cfg.record_interval};
            end
            AGE_WINDOW:
            begin
                hit = (age <= {11'd0, cfg.trend_window, 1'b0}) &&
                      (age >= {13'd0, cfg.trend_window[19:1]});
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/shtt_ctrl.sv
// Sequencer: compaction, append, eviction and reference scan over the ring.
`timescale 1ns / 1ps
module shtt_ctrl
    import shtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  in_t                        sample_word,
    output logic                       trend_valid,
    input  logic                       trend_stall,
    output out_t                       trend_word,
    output logic                       ring_we,
    output logic [$clog2(SLOTS)-1:0]   ring_waddr,
    output entry_t                     ring_wdata,
    output logic [$clog2(SLOTS)-1:0]   ring_raddr,
    input  entry_t                     ring_rdata,
    output age_op_t                    age_op,
    output logic [31:0]                age_now,
    output logic [31:0]                age_stamp,
    input  logic                       age_hit
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    function automatic trend_t classify(
        input logic               latest_ok,
        input logic               found,
        input logic signed [15:0] latest,
        input logic signed [15:0] ref_val,
        input logic [14:0]        thr
    );
        logic signed [16:0] diff;
        logic signed [16:0] lim;
        trend_t             res;
        diff = 17'(latest) - 17'(ref_val);
        lim  = $signed({2'b00, thr});
        if (!latest_ok || !found)
            res = TR_UNKNOWN;
        else if (diff >= lim)
            res = TR_UP;
        else if (diff <= -lim)
            res = TR_DOWN;
        else
            res = TR_FLAT;
        return res;
    endfunction

    state_t             state_reg, state_next;
    entry_t             smp_reg, smp_next;
    entry_t             newest_reg, newest_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      wr_idx_reg, wr_idx_next;
    logic [AW-1:0]      rsp_idx_reg, rsp_idx_next;
    logic               pend_reg, pend_next;
    logic               recorded_reg, recorded_next;
    logic               p_found_reg, p_found_next;
    logic               t_found_reg, t_found_next;
    logic signed [15:0] p_ref_reg, p_ref_next;
    logic signed [15:0] t_ref_reg, t_ref_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_word_reg, out_word_next;

    logic               scanning;
    logic [CW-1:0]      scan_end;
    logic               issue;
    logic               scan_done;
    logic               do_append;
    logic               out_free;

    // Scan bounds of the three passes over the ring.
    always_comb
    begin
        scanning = 1'b0;
        scan_end = '0;
        case (state_reg)
            ST_COMPACT:
            begin
                scanning = 1'b1;
                scan_end = count_reg;
            end
            ST_SHIFT:
            begin
                scanning = 1'b1;
                scan_end = CW'(SLOTS);
            end
            ST_SCAN:
            begin
                scanning = 1'b1;
                scan_end = CW'(count_reg - CW'(1));
            end
            default:
            begin
                scanning = 1'b0;
            end
        endcase
    end

    assign issue     = scanning && (rd_idx_reg < scan_end);
    assign scan_done = !issue && !pend_reg;
    assign do_append = (count_reg == CW'(0)) || age_hit;
    assign out_free  = !out_valid_reg || !trend_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_COMPACT;
            end
            ST_COMPACT:
            begin
                if (scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!do_append)
                    state_next = ST_SCAN;
                else if (count_reg == CW'(SLOTS))
                    state_next = ST_SHIFT;
                else
                    state_next = ST_APPEND;
            end
            ST_SHIFT:
            begin
                if (scan_done)
                    state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        smp_next       = smp_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        rsp_idx_next   = rsp_idx_reg;
        pend_next      = issue;
        recorded_next  = recorded_reg;
        p_found_next   = p_found_reg;
        t_found_next   = t_found_reg;
        p_ref_next     = p_ref_reg;
        t_ref_next     = t_ref_reg;
        out_valid_next = out_valid_reg && trend_stall;
        out_word_next  = out_word_reg;

        ring_we    = 1'b0;
        ring_waddr = '0;
        ring_wdata = ring_rdata;
        ring_raddr = rd_idx_reg[AW-1:0];
        age_op     = AGE_KEEP;
        age_now    = smp_reg.stamp;
        age_stamp  = ring_rdata.stamp;

        if (issue)
        begin
            rd_idx_next  = CW'(rd_idx_reg + CW'(1));
            rsp_idx_next = rd_idx_reg[AW-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    smp_next.stamp          = sample_word.now_seconds;
                    smp_next.pressure       = sample_word.pressure_tenths;
                    smp_next.temperature    = sample_word.temperature_hundredths;
                    smp_next.pressure_ok    = sample_word.pressure_known;
                    smp_next.temperature_ok = sample_word.temperature_known;
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    recorded_next = 1'b0;
                    p_found_next  = 1'b0;
                    t_found_next  = 1'b0;
                end
            end
            ST_COMPACT:
            begin
                // keep entries that are neither in the future nor too old
                age_op = AGE_KEEP;
                if (pend_reg && age_hit)
                begin
                    ring_we     = 1'b1;
                    ring_waddr  = wr_idx_reg[AW-1:0];
                    wr_idx_next = CW'(wr_idx_reg + CW'(1));
                    newest_next = ring_rdata;
                end
                if (scan_done)
                    count_next = wr_idx_reg;
            end
            ST_DECIDE:
            begin
                age_op    = AGE_INTERVAL;
                age_stamp = newest_reg.stamp;
                if (do_append)
                    recorded_next = 1'b1;
                // the shift starts at entry one, the scan at entry zero
                rd_idx_next = (do_append && count_reg == CW'(SLOTS)) ? CW'(1) : '0;
            end
            ST_SHIFT:
            begin
                // drop the oldest entry: move each entry down one place
                if (pend_reg)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = AW'(rsp_idx_reg - AW'(1));
                end
                if (scan_done)
                    count_next = CW'(SLOTS - 1);
            end
            ST_APPEND:
            begin
                ring_we     = 1'b1;
                ring_waddr  = count_reg[AW-1:0];
                ring_wdata  = smp_reg;
                count_next  = CW'(count_reg + CW'(1));
                newest_next = smp_reg;
                rd_idx_next = '0;
            end
            ST_SCAN:
            begin
                // first earlier known sample inside the age window
                age_op = AGE_WINDOW;
                if (pend_reg && age_hit)
                begin
                    if (!p_found_reg && ring_rdata.pressure_ok)
                    begin
                        p_found_next = 1'b1;
                        p_ref_next   = ring_rdata.pressure;
                    end
                    if (!t_found_reg && ring_rdata.temperature_ok)
                    begin
                        t_found_next = 1'b1;
                        t_ref_next   = ring_rdata.temperature;
                    end
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next.pressure_trend = classify(newest_reg.pressure_ok,
                        p_found_reg, newest_reg.pressure, p_ref_reg,
                        cfg.pressure_threshold);
                    out_word_next.indoor_trend = classify(newest_reg.temperature_ok,
                        t_found_reg, newest_reg.temperature, t_ref_reg,
                        cfg.temperature_threshold);
                    out_word_next.sample_recorded = recorded_reg;
                    out_word_next.stored_count    = 5'(count_reg);
                end
            end
            default:
            begin
                ring_we = 1'b0;
            end
        endcase
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign trend_valid  = out_valid_reg;
    assign trend_word   = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            recorded_reg  <= 1'b0;
            p_found_reg   <= 1'b0;
            t_found_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            pend_reg      <= pend_next;
            recorded_reg  <= recorded_next;
            p_found_reg   <= p_found_next;
            t_found_reg   <= t_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        newest_reg   <= newest_next;
        rsp_idx_reg  <= rsp_idx_next;
        p_ref_reg    <= p_ref_next;
        t_ref_reg    <= t_ref_next;
        out_word_reg <= out_word_next;
    end

endmodule

>>> sv/sample_history_trend_tracker_top.sv
// Top level of the sample history trend tracker: config registers and datapath wiring.
//
//  channel  | dir | handshake              | word
//  ---------+-----+------------------------+--------------------------------------
//  sample   | in  | sample_valid / _stall  | in_t: time, pressure, temperature
//  trend    | out | trend_valid / _stall   | out_t: two trends, recorded, count
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (20 bits)
//
//  With one or more stored samples all kept and the new one appended, the result
//  passes through the compact pass, decide, append, the scan pass and report before
//  it loads; a full ring adds a shift pass after decide to evict the oldest entry.
//  Reset empties the ring at once; the sample store itself is not cleared.
//  sample_stall is high from the accepting edge until the result is loaded.
`timescale 1ns / 1ps
module sample_history_trend_tracker_top
    import shtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  in_t                     sample_word,
    output logic                    trend_valid,
    input  logic                    trend_stall,
    output out_t                    trend_word,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(SLOTS);

    cfg_t    cfg_reg, cfg_next;

    logic    ring_we;
    logic [AW-1:0] ring_waddr;
    logic [AW-1:0] ring_raddr;
    entry_t  ring_wdata;
    entry_t  ring_rdata;

    age_op_t       age_op;
    logic [31:0]   age_now;
    logic [31:0]   age_stamp;
    logic          age_hit;

    // The user must land config writes only while idle; unchecked, they are taken every cycle.
    assign cfg_ready = 1'b1;

    // Register decode: truncate the data to each register's width,
    // drop writes to indexes past the list.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RECORD_INTERVAL:
                    cfg_next.record_interval = cfg_data[16:0];
                CFG_MAX_SAMPLE_AGE:
                    cfg_next.max_sample_age = cfg_data[19:0];
                CFG_TREND_WINDOW:
                    cfg_next.trend_window = cfg_data[19:0];
                CFG_PRESSURE_THRESHOLD:
                    cfg_next.pressure_threshold = cfg_data[14:0];
                CFG_TEMPERATURE_THRESHOLD:
                    cfg_next.temperature_threshold = cfg_data[14:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_interval       <= RECORD_INTERVAL_RESET;
            cfg_reg.max_sample_age        <= MAX_SAMPLE_AGE_RESET;
            cfg_reg.trend_window          <= TREND_WINDOW_RESET;
            cfg_reg.pressure_threshold    <= PRESSURE_THRESHOLD_RESET;
            cfg_reg.temperature_threshold <= TEMPERATURE_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: owns the sample and trend handshakes, the ring pointers and the output register.
    shtt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .trend_valid  (trend_valid),
        .trend_stall  (trend_stall),
        .trend_word   (trend_word),
        .ring_we      (ring_we),
        .ring_waddr   (ring_waddr),
        .ring_wdata   (ring_wdata),
        .ring_raddr   (ring_raddr),
        .ring_rdata   (ring_rdata),
        .age_op       (age_op),
        .age_now      (age_now),
        .age_stamp    (age_stamp),
        .age_hit      (age_hit)
    );

    // Sample store, oldest entry at index zero.
    shtt_ring #(
        .SLOTS (SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // One age subtractor and compare, shared by the compaction pass, the decide step and the reference scan.
    shtt_age_unit u_age (
        .cfg   (cfg_reg),
        .op    (age_op),
        .now   (age_now),
        .stamp (age_stamp),
        .hit   (age_hit)
    );

endmodule

>>> sv/shtt_checker.sv
// Port-level checker for the trend tracker and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module shtt_checker
    import shtt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sample_valid,
    input logic                    sample_stall,
    input in_t                     sample_word,
    input logic                    trend_valid,
    input logic                    trend_stall,
    input out_t                    trend_word,
    input logic                    cfg_valid,
    input logic                    cfg_ready
);

    // hold a stalled result word
    `SHTT_ASSERT_NEXT(a_result_held, clk, rst_n, trend_valid && trend_stall,
        trend_valid && $stable(trend_word))

    // hold a stalled sample word
    `SHTT_ASSERT_NEXT(a_sample_held, clk, rst_n, sample_valid && sample_stall,
        sample_valid && $stable(sample_word))

    // one word at a time: busy right after taking a sample
    `SHTT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall,
        sample_stall)

    // a result never appears in the cycle right after a sample is taken
    `SHTT_ASSERT_NEXT(a_no_instant_result, clk, rst_n, sample_valid && !sample_stall,
        !$rose(trend_valid))

    // register writes are never held off
    `SHTT_ASSERT_NOW(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind sample_history_trend_tracker_top shtt_checker u_checker (.*);
